// File: rtl/fatl_pkg.sv
// Shared types and constants for the fully associative TLB.
// Used by every module of the block; depends on nothing.
package fatl_pkg;

   localparam logic       OP_LOOKUP       = 1'b0;
   localparam logic       OP_FILL         = 1'b1;
   localparam logic [4:0] PAGE_LOG2_RESET = 5'd4;

   typedef struct packed {
      logic        operation;
      logic [31:0] virtual_address;
      logic [31:0] physical_address;
      logic [31:0] cycle;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [3:0]  entry_index;
      logic [31:0] physical_address_out;
   } rsp_type;

   // write controls toward the entry store
   typedef struct packed {
      logic stamp;  // write last-use only
      logic fill;   // write tag, frame, valid and last-use
   } wr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

// File: rtl/fatl_entry_store.sv
// Entry storage of the TLB: tag, frame and last-use memories plus valid flops.
// One registered read port, one write port; depends on fatl_pkg.
module fatl_entry_store
   import fatl_pkg::*;
#(
   parameter int ENTRIES = 16,
   parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] rd_addr,
   output logic             rd_valid,
   output logic [31:0]      rd_tag,
   output logic [31:0]      rd_frame,
   output logic [31:0]      rd_stamp,
   input  wr_type           wr_ctl,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [31:0]      wr_tag,
   input  logic [31:0]      wr_frame,
   input  logic [31:0]      wr_stamp
);

   logic [31:0] tag_mem   [ENTRIES];
   logic [31:0] frame_mem [ENTRIES];
   logic [31:0] stamp_mem [ENTRIES];
   logic        valid_ff  [ENTRIES];

   logic        rd_valid_ff;
   logic [31:0] rd_tag_ff;
   logic [31:0] rd_frame_ff;
   logic [31:0] rd_stamp_ff;

   always_ff @(posedge clock) begin
      if (wr_ctl.fill) begin
         tag_mem[wr_addr]   <= wr_tag;
         frame_mem[wr_addr] <= wr_frame;
      end
      if (wr_ctl.fill || wr_ctl.stamp) begin
         stamp_mem[wr_addr] <= wr_stamp;
      end
      rd_tag_ff   <= tag_mem[rd_addr];
      rd_frame_ff <= frame_mem[rd_addr];
      rd_stamp_ff <= stamp_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
         end
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_ctl.fill) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // an entry never filled reads as zeros
   assign rd_valid = rd_valid_ff;
   assign rd_tag   = rd_valid_ff ? rd_tag_ff   : 32'd0;
   assign rd_frame = rd_valid_ff ? rd_frame_ff : 32'd0;
   assign rd_stamp = rd_valid_ff ? rd_stamp_ff : 32'd0;

endmodule

// File: rtl/fatl_scan_ctrl.sv
// Sequencer of the TLB: walks the entries one per cycle through one shared
// comparator, then writes back and issues the result. Depends on fatl_pkg.
module fatl_scan_ctrl
   import fatl_pkg::*;
#(
   parameter int ENTRIES = 16,
   parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic [4:0]       page_log2,
   output logic [IDX_W-1:0] rd_addr,
   input  logic             rd_valid,
   input  logic [31:0]      rd_tag,
   input  logic [31:0]      rd_frame,
   input  logic [31:0]      rd_stamp,
   output wr_type           wr_ctl,
   output logic [IDX_W-1:0] wr_addr,
   output logic [31:0]      wr_tag,
   output logic [31:0]      wr_frame,
   output logic [31:0]      wr_stamp
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [31:0]      vpn_ff, vpn_in;
   logic [31:0]      pfn_ff, pfn_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             live_ff, live_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] best_ff, best_in;
   logic [31:0]      least_ff, least_in;
   logic [31:0]      best_frame_ff, best_frame_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             accept;
   logic             is_fill;
   logic [31:0]      cmp_a;
   logic [31:0]      cmp_b;
   logic             cmp_eq;
   logic             cmp_lt;
   logic [31:0]      offset_mask;
   logic [31:0]      phys;
   logic [IDX_W+3:0] best_ext;

   assign accept  = start && !busy;
   assign is_fill = (req_ff.operation == OP_FILL);

   // shared comparator: tag match on lookup, age compare on fill
   assign cmp_a  = is_fill ? rd_stamp : rd_tag;
   assign cmp_b  = is_fill ? least_ff : vpn_ff;
   assign cmp_eq = (cmp_a == cmp_b);
   assign cmp_lt = (cmp_a < cmp_b);

   assign offset_mask = (32'd1 << page_log2) - 32'd1;
   assign phys        = (best_frame_ff << page_log2)
                        + (req_ff.virtual_address & offset_mask);
   assign best_ext    = {4'd0, best_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (start) state_in = ST_SCAN;
         ST_SCAN:  if (cnt_ff == LAST_IDX) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy         = 1'b1;
      live_in      = 1'b0;
      rsp_valid_in = 1'b0;
      wr_ctl       = '0;
      unique case (state_ff)
         ST_IDLE:  busy = 1'b0;
         ST_SCAN:  live_in = 1'b1;
         ST_DRAIN: ;
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            wr_ctl.fill  = is_fill;
            wr_ctl.stamp = !is_fill && found_ff;
         end
         default:  busy = 1'b1;
      endcase
   end

   always_comb begin
      req_in        = req_ff;
      vpn_in        = vpn_ff;
      pfn_in        = pfn_ff;
      cnt_in        = cnt_ff;
      cmp_idx_in    = cnt_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      least_in      = least_ff;
      best_frame_in = best_frame_ff;
      rsp_in        = rsp_ff;

      if (accept) begin
         req_in   = req_data;
         vpn_in   = req_data.virtual_address >> page_log2;
         pfn_in   = req_data.physical_address >> page_log2;
         cnt_in   = '0;
         found_in = 1'b0;
         best_in  = '0;
      end else if (state_ff == ST_SCAN && cnt_ff != LAST_IDX) begin
         cnt_in = cnt_ff + 1'b1;
      end

      if (live_ff && !found_ff) begin
         if (is_fill) begin
            if (!rd_valid) begin
               found_in = 1'b1;
               best_in  = cmp_idx_ff;
            end else if (cmp_idx_ff == '0 || cmp_lt) begin
               least_in = rd_stamp;
               best_in  = cmp_idx_ff;
            end
         end else if (rd_valid && cmp_eq) begin
            found_in      = 1'b1;
            best_in       = cmp_idx_ff;
            best_frame_in = rd_frame;
         end
      end

      if (state_ff == ST_DONE) begin
         rsp_in.hit                  = is_fill || found_ff;
         rsp_in.entry_index          = (is_fill || found_ff) ? best_ext[3:0] : 4'd0;
         rsp_in.physical_address_out = (!is_fill && found_ff) ? phys : 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         live_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      vpn_ff        <= vpn_in;
      pfn_ff        <= pfn_in;
      cnt_ff        <= cnt_in;
      cmp_idx_ff    <= cmp_idx_in;
      best_ff       <= best_in;
      least_ff      <= least_in;
      best_frame_ff <= best_frame_in;
      rsp_ff        <= rsp_in;
   end

   assign rd_addr   = cnt_ff;
   assign wr_addr   = best_ff;
   assign wr_tag    = vpn_ff;
   assign wr_frame  = pfn_ff;
   assign wr_stamp  = req_ff.cycle;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/fully_associative_tlb_lru.sv
// Top level of the fully associative TLB with LRU replacement.
// Holds the page size register; instantiates fatl_scan_ctrl and fatl_entry_store.
//
//   channel  ports                        transfer
//   -------  ---------------------------  ------------------------------------
//   request  start, busy, req_data        start high while busy low
//   result   rsp_valid, rsp_data          rsp_valid high, one cycle, no stall
//   config   csr_valid, csr_ready,        csr_valid and csr_ready both high
//            csr_data
//
// For each item the sequencer reads one entry a cycle from the store's single
// read port and feeds it to the shared comparator, then makes the last compare
// in the drain state and writes back in the done state. The result shows on
// rsp_data for one cycle while the block already takes the next request.
// Synchronous reset clears all valid bits at once and sets the page size to 16
// bytes; no clearing pass follows.
module fully_associative_tlb_lru
   import fatl_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [4:0] csr_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic [4:0]       page_log2_ff;

   logic [IDX_W-1:0] rd_addr;
   logic             rd_valid;
   logic [31:0]      rd_tag;
   logic [31:0]      rd_frame;
   logic [31:0]      rd_stamp;
   wr_type           wr_ctl;
   logic [IDX_W-1:0] wr_addr;
   logic [31:0]      wr_tag;
   logic [31:0]      wr_frame;
   logic [31:0]      wr_stamp;

   // the user must send writes only while idle; the block does not enforce it and always takes them
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_log2_ff <= PAGE_LOG2_RESET;
      end else if (csr_valid && csr_ready) begin
         page_log2_ff <= csr_data;
      end
   end

   fatl_scan_ctrl #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .page_log2 (page_log2_ff),
      .rd_addr   (rd_addr),
      .rd_valid  (rd_valid),
      .rd_tag    (rd_tag),
      .rd_frame  (rd_frame),
      .rd_stamp  (rd_stamp),
      .wr_ctl    (wr_ctl),
      .wr_addr   (wr_addr),
      .wr_tag    (wr_tag),
      .wr_frame  (wr_frame),
      .wr_stamp  (wr_stamp)
   );

   fatl_entry_store #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (rd_addr),
      .rd_valid (rd_valid),
      .rd_tag   (rd_tag),
      .rd_frame (rd_frame),
      .rd_stamp (rd_stamp),
      .wr_ctl   (wr_ctl),
      .wr_addr  (wr_addr),
      .wr_tag   (wr_tag),
      .wr_frame (wr_frame),
      .wr_stamp (wr_stamp)
   );

endmodule
